// ===== design/dlsq_pkg.sv =====
// Shared constants, types and helpers for the delta-list sleep queue.
// Used by dlsq_div, dlsq_engine and delta_list_sleep_queue_unit; no dependencies.
package dlsq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MS_PER_TICK = 10;

  localparam int ID_W       = 8;
  localparam int MS_W       = 32;
  localparam int DELTA_W    = 29;
  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Truncating divide by MS_PER_TICK as a multiply by a rounded-up reciprocal.
  localparam int DIV_SHIFT = MS_W + $clog2(MS_PER_TICK);
  localparam int RECIP_W   = MS_W + 1;
  localparam int PROD_W    = MS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(MS_PER_TICK) - 64'd1) / 64'(MS_PER_TICK));

  localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] target_id;
    logic            status;
    logic            last;
  } result_t;

  // Map a position in the list (0 = head) onto a slot of the ring.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(ofs);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== design/dlsq_div.sv =====
// Divider of the millisecond count by the tick period: a registered multiply
// by a rounded-up reciprocal, start registered into busy and then into done; depends on dlsq_pkg.
module dlsq_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dlsq_pkg::MS_W-1:0] dividend,
  output logic                      done,
  output logic [dlsq_pkg::MS_W-1:0] quotient
);

  logic                        busy_r;
  logic                        done_r;
  logic [dlsq_pkg::MS_W-1:0]   dvd_r;
  logic [dlsq_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (busy_r) begin
      prod_r <= dlsq_pkg::PROD_W'(dvd_r) * dlsq_pkg::PROD_W'(dlsq_pkg::DIV_RECIP);
    end
  end

  assign done     = done_r;
  assign quotient = dlsq_pkg::MS_W'(prod_r >> dlsq_pkg::DIV_SHIFT);

endmodule

// ===== design/dlsq_engine.sv =====
// Delta-list store and its sequencer: ring memory of entries, insert walk, tick pops.
// Depends on dlsq_pkg; takes the tick count from dlsq_div.
module dlsq_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [dlsq_pkg::ID_W-1:0] in_process_id,
  input  logic [dlsq_pkg::MS_W-1:0] in_duration_ms,
  output logic                      div_start,
  output logic [dlsq_pkg::MS_W-1:0] div_dividend,
  input  logic                      div_done,
  input  logic [dlsq_pkg::MS_W-1:0] div_quotient,
  output logic                      res_valid,
  input  logic                      res_ready,
  output dlsq_pkg::result_t         res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WALK,
    S_REPLY,
    S_TK_HEAD,
    S_TK_NEXT
  } state_t;

  state_t state_r, state_nxt;

  logic [dlsq_pkg::IDX_W-1:0]   head_r, head_nxt;
  logic [dlsq_pkg::CNT_W-1:0]   occ_r, occ_nxt;
  logic [dlsq_pkg::CNT_W-1:0]   proc_r, proc_nxt;
  logic                         inserted_r, inserted_nxt;
  logic [dlsq_pkg::ID_W-1:0]    pid_r, pid_nxt;
  logic [dlsq_pkg::DELTA_W-1:0] ticks_r, ticks_nxt;
  logic [dlsq_pkg::DELTA_W-1:0] sum_r, sum_nxt;
  logic                         status_r, status_nxt;
  dlsq_pkg::entry_t             carry_r, carry_nxt;

  dlsq_pkg::entry_t             mem [dlsq_pkg::QUEUE_DEPTH];
  dlsq_pkg::entry_t             rd_data_r;
  logic [dlsq_pkg::IDX_W-1:0]   rd_addr;
  logic [dlsq_pkg::IDX_W-1:0]   wr_addr;
  dlsq_pkg::entry_t             wr_data;
  logic                         mem_we;

  logic                         have;
  logic                         more;
  logic [dlsq_pkg::DELTA_W:0]   walk_sum;
  logic [dlsq_pkg::DELTA_W-1:0] new_delta;
  logic [dlsq_pkg::DELTA_W-1:0] dec_delta;
  logic [dlsq_pkg::DELTA_W-1:0] sat_ticks;

  assign div_dividend = in_duration_ms;

  // Saturate the tick count to the delta width; a sub-tick sleep counts as one.
  always_comb begin
    if (|div_quotient[dlsq_pkg::MS_W-1:dlsq_pkg::DELTA_W]) begin
      sat_ticks = dlsq_pkg::DELTA_MAX;
    end else if (div_quotient == '0) begin
      sat_ticks = dlsq_pkg::DELTA_W'(1);
    end else begin
      sat_ticks = div_quotient[dlsq_pkg::DELTA_W-1:0];
    end
  end

  assign have      = proc_r < occ_r;
  assign walk_sum  = {1'b0, sum_r} + {1'b0, rd_data_r.delta};
  assign new_delta = ticks_r - sum_r;
  assign dec_delta = (rd_data_r.delta == '0) ? '0
                                             : rd_data_r.delta - dlsq_pkg::DELTA_W'(1);
  assign more      = (occ_r != '0) && (rd_data_r.delta == '0);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    proc_nxt     = proc_r;
    inserted_nxt = inserted_r;
    pid_nxt      = pid_r;
    ticks_nxt    = ticks_r;
    sum_nxt      = sum_r;
    status_nxt   = status_r;
    carry_nxt    = carry_r;
    rd_addr      = head_r;
    wr_addr      = dlsq_pkg::slot_of(head_r, proc_r);
    wr_data      = carry_r;
    mem_we       = 1'b0;
    in_ready     = 1'b0;
    div_start    = 1'b0;
    res_valid    = 1'b0;
    res          = '{kind: dlsq_pkg::KIND_ACK, target_id: pid_r,
                     status: status_r, last: 1'b1};

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pid_nxt = in_process_id;
          if (in_action == dlsq_pkg::ACT_SLEEP) begin
            if (occ_r == dlsq_pkg::CNT_W'(dlsq_pkg::QUEUE_DEPTH)) begin
              status_nxt = dlsq_pkg::STAT_FULL;
              state_nxt  = S_REPLY;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else if (occ_r != '0) begin
            state_nxt = S_TK_HEAD;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          ticks_nxt    = sat_ticks;
          sum_nxt      = '0;
          proc_nxt     = '0;
          inserted_nxt = 1'b0;
          state_nxt    = S_WALK;
        end
      end

      // One list position per cycle: read ahead, skip earlier or equal deadlines,
      // drop the new entry in, then ripple the rest down by one slot.
      S_WALK: begin
        rd_addr = dlsq_pkg::slot_of(head_r, proc_r + dlsq_pkg::CNT_W'(1));
        if (!inserted_r) begin
          if (have && (walk_sum <= {1'b0, ticks_r})) begin
            sum_nxt = walk_sum[dlsq_pkg::DELTA_W-1:0];
          end else begin
            mem_we       = 1'b1;
            wr_data      = '{delta: new_delta, id: pid_r};
            inserted_nxt = 1'b1;
            carry_nxt    = '{delta: rd_data_r.delta - new_delta, id: rd_data_r.id};
          end
        end else begin
          mem_we    = 1'b1;
          wr_data   = carry_r;
          carry_nxt = rd_data_r;
        end
        if (proc_r == occ_r) begin
          occ_nxt    = occ_r + dlsq_pkg::CNT_W'(1);
          status_nxt = dlsq_pkg::STAT_OK;
          state_nxt  = S_REPLY;
        end else begin
          proc_nxt = proc_r + dlsq_pkg::CNT_W'(1);
        end
      end

      S_REPLY: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_TK_HEAD: begin
        if (dec_delta != '0) begin
          mem_we    = 1'b1;
          wr_addr   = head_r;
          wr_data   = '{delta: dec_delta, id: rd_data_r.id};
          state_nxt = S_IDLE;
        end else begin
          pid_nxt   = rd_data_r.id;
          head_nxt  = dlsq_pkg::slot_of(head_r, dlsq_pkg::CNT_W'(1));
          occ_nxt   = occ_r - dlsq_pkg::CNT_W'(1);
          rd_addr   = dlsq_pkg::slot_of(head_r, dlsq_pkg::CNT_W'(1));
          state_nxt = S_TK_NEXT;
        end
      end

      // Hold the pending wake until the next head shows whether it is the last.
      S_TK_NEXT: begin
        res_valid = 1'b1;
        res       = '{kind: dlsq_pkg::KIND_WAKE, target_id: pid_r,
                      status: dlsq_pkg::STAT_OK, last: !more};
        if (res_ready) begin
          if (more) begin
            pid_nxt  = rd_data_r.id;
            head_nxt = dlsq_pkg::slot_of(head_r, dlsq_pkg::CNT_W'(1));
            occ_nxt  = occ_r - dlsq_pkg::CNT_W'(1);
            rd_addr  = dlsq_pkg::slot_of(head_r, dlsq_pkg::CNT_W'(1));
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      occ_r      <= '0;
      proc_r     <= '0;
      inserted_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      occ_r      <= occ_nxt;
      proc_r     <= proc_nxt;
      inserted_r <= inserted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r    <= pid_nxt;
    ticks_r  <= ticks_nxt;
    sum_r    <= sum_nxt;
    status_r <= status_nxt;
    carry_r  <= carry_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && (proc_r == occ_r) |-> mem_we)
    else $error("insert walk ended without writing the final slot");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && (proc_r == occ_r) |=>
      (occ_r == $past(occ_r) + dlsq_pkg::CNT_W'(1)))
    else $error("insert did not grow the list by one");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rd_addr != wr_addr))
    else $error("walk read ahead collides with its own write");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TK_NEXT) && res_ready && more |=>
      (occ_r == $past(occ_r) - dlsq_pkg::CNT_W'(1)))
    else $error("woken entry was not popped from the list");

  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= dlsq_pkg::CNT_W'(dlsq_pkg::QUEUE_DEPTH))
    else $error("list occupancy beyond its depth");

endmodule

// ===== design/delta_list_sleep_queue_unit.sv =====
// Delta-list sleep queue top level: divider, list engine and output register.
// Depends on dlsq_pkg, dlsq_div and dlsq_engine.
//
// A sleep item first turns milliseconds into ticks by a reciprocal multiply,
// then walks one list position per cycle (N + 1 of them, with N the number
// of queued sleepers) as the single-read-port ring memory is walked and the
// tail rippled down by one slot, and then hands the result over. A sleep
// rejected on a full queue goes straight to its reply. A tick whose head is
// not yet due gives no result, and the engine passes its head check back to
// idle before the next item is taken. Otherwise the head's wake result is
// offered first and each further wake follows once the previous one is taken,
// each needing a memory read of the next head. A tick on an empty queue gives
// no result and the next item can be taken on the following cycle. Results sit
// in an output register, so the next item is taken while the previous result
// waits; a stalled output holds the engine at its next result.
module delta_list_sleep_queue_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [dlsq_pkg::ID_W-1:0] in_process_id,
  input  logic [dlsq_pkg::MS_W-1:0] in_duration_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [dlsq_pkg::ID_W-1:0] out_target_id,
  output logic                      out_status,
  output logic                      out_last
);

  logic                      div_start;
  logic [dlsq_pkg::MS_W-1:0] div_dividend;
  logic                      div_done;
  logic [dlsq_pkg::MS_W-1:0] div_quotient;

  logic                      res_valid;
  logic                      res_ready;
  dlsq_pkg::result_t         res;

  logic                      out_valid_r;
  dlsq_pkg::result_t         out_res_r;

  dlsq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quotient)
  );

  dlsq_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_process_id  (in_process_id),
    .in_duration_ms (in_duration_ms),
    .div_start      (div_start),
    .div_dividend   (div_dividend),
    .div_done       (div_done),
    .div_quotient   (div_quotient),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // Load a new item whenever the register is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_res_r.kind;
  assign out_target_id = out_res_r.target_id;
  assign out_status    = out_res_r.status;
  assign out_last      = out_res_r.last;

endmodule

// ===== dv/delta_list_sleep_queue_unit_tb.sv =====
// Self-checking bench for delta_list_sleep_queue_unit: sleep and tick items in,
// acknowledgements and wake results out, checked against a delta-list shadow.
// Depends on dlsq_pkg and the RTL of the unit.
module delta_list_sleep_queue_unit_tb;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 250;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_action;
  logic [dlsq_pkg::ID_W-1:0]      in_process_id;
  logic [dlsq_pkg::MS_W-1:0]      in_duration_ms;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_kind;
  logic [dlsq_pkg::ID_W-1:0]      out_target_id;
  logic                           out_status;
  logic                           out_last;

  // Shadow of the sleeper list and the results the block still owes.
  logic [dlsq_pkg::DELTA_W-1:0] shadow_delta [dlsq_pkg::QUEUE_DEPTH];
  logic [dlsq_pkg::ID_W-1:0]    shadow_id    [dlsq_pkg::QUEUE_DEPTH];
  int                           shadow_count;
  dlsq_pkg::result_t            owed_results [$];
  dlsq_pkg::result_t            want;

  int   mismatches  = 0;
  int   idle_cycles = 0;
  bit   rx_idle_on;
  bit   tx_idle_on;
  bit   rx_hold;
  event hold_req;

  delta_list_sleep_queue_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_process_id  (in_process_id),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_target_id  (out_target_id),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic dlsq_pkg::result_t pack_result(input logic kind,
                                                    input logic [dlsq_pkg::ID_W-1:0] pid,
                                                    input logic status, input logic last);
    dlsq_pkg::result_t r;
    r.kind      = kind;
    r.target_id = pid;
    r.status    = status;
    r.last      = last;
    return r;
  endfunction

  // Insert a sleeper after every entry with an earlier or equal deadline.
  function automatic void apply_sleep(input logic [dlsq_pkg::ID_W-1:0] pid,
                                      input logic [dlsq_pkg::MS_W-1:0] ms);
    logic [31:0]                  ticks;
    logic [31:0]                  sum;
    logic [dlsq_pkg::DELTA_W-1:0] nd;
    int                           pos;
    int                           k;
    if (shadow_count >= dlsq_pkg::QUEUE_DEPTH) begin
      owed_results.push_back(pack_result(dlsq_pkg::KIND_ACK, pid, dlsq_pkg::STAT_FULL, 1'b1));
      return;
    end
    ticks = ms / 32'(dlsq_pkg::MS_PER_TICK);
    if (ticks == 32'd0) ticks = 32'd1;
    if (ticks > 32'(dlsq_pkg::DELTA_MAX)) ticks = 32'(dlsq_pkg::DELTA_MAX);
    sum = 32'd0;
    pos = 0;
    while (pos < shadow_count && sum + 32'(shadow_delta[pos]) <= ticks) begin
      sum = sum + 32'(shadow_delta[pos]);
      pos++;
    end
    nd = dlsq_pkg::DELTA_W'(ticks - sum);
    for (k = shadow_count; k > pos; k--) begin
      shadow_delta[k] = shadow_delta[k-1];
      shadow_id[k]    = shadow_id[k-1];
    end
    shadow_delta[pos] = nd;
    shadow_id[pos]    = pid;
    shadow_count++;
    if (pos + 1 < shadow_count) shadow_delta[pos+1] = shadow_delta[pos+1] - nd;
    owed_results.push_back(pack_result(dlsq_pkg::KIND_ACK, pid, dlsq_pkg::STAT_OK, 1'b1));
  endfunction

  // Age the head, then pop every leading entry that is due.
  function automatic void apply_tick();
    int   n;
    int   k;
    logic fin;
    if (shadow_count == 0) return;
    if (shadow_delta[0] != '0) shadow_delta[0] = shadow_delta[0] - dlsq_pkg::DELTA_W'(1);
    n = 0;
    while (n < shadow_count && shadow_delta[n] == '0) begin
      fin = !(n + 1 < shadow_count && shadow_delta[n+1] == '0);
      owed_results.push_back(pack_result(dlsq_pkg::KIND_WAKE, shadow_id[n],
                                         dlsq_pkg::STAT_OK, fin));
      n++;
    end
    if (n == 0) return;
    for (k = n; k < shadow_count; k++) begin
      shadow_delta[k-n] = shadow_delta[k];
      shadow_id[k-n]    = shadow_id[k];
    end
    shadow_count = shadow_count - n;
  endfunction

  function automatic logic [dlsq_pkg::MS_W-1:0] pick_duration();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return dlsq_pkg::MS_W'($urandom_range(0, 80));
    if (sel < 95) return dlsq_pkg::MS_W'($urandom_range(0, 1000));
    return dlsq_pkg::MS_W'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("ERROR: %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
    mismatches++;
  endtask

  // Offer one item and update the shadow on the edge that takes it.
  task automatic send_item(input logic act, input logic [dlsq_pkg::ID_W-1:0] pid,
                           input logic [dlsq_pkg::MS_W-1:0] ms);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_action      <= act;
    in_process_id  <= pid;
    in_duration_ms <= ms;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (act == dlsq_pkg::ACT_SLEEP) apply_sleep(pid, ms);
    else apply_tick();
  endtask

  task automatic send_sleep(input logic [dlsq_pkg::ID_W-1:0] pid,
                            input logic [dlsq_pkg::MS_W-1:0] ms);
    send_item(dlsq_pkg::ACT_SLEEP, pid, ms);
  endtask

  task automatic send_tick();
    send_item(dlsq_pkg::ACT_TICK, dlsq_pkg::ID_W'($urandom()), dlsq_pkg::MS_W'($urandom()));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_tick();                       // empty queue: no result
    send_sleep(8'h00, 32'd0);          // shorter than a tick wakes next tick
    send_tick();
    send_sleep(8'hFF, 32'hFFFF_FFFF);  // longest sleep, stays queued
    send_sleep(8'h11, 32'd9);
    send_sleep(8'h12, 32'd10);
    send_sleep(8'h13, 32'd19);         // three equal deadlines
    send_sleep(8'h14, 32'd30);
    send_sleep(8'h15, 32'd20);         // lands mid-list, trims successor
    send_sleep(8'h16, 32'd20);         // queues after its equal
    send_tick();
    send_tick();
    send_tick();
    send_tick();                       // head not yet due: no result
    send_sleep(8'hAA, 32'h5555_5555);
    send_sleep(8'h55, 32'hAAAA_AAAA);
    wait_for_results();
  endtask

  // Fill to capacity with near deadlines, bounce extra sleeps, then wake in bulk.
  task automatic test_fill_queue();
    while (shadow_count < dlsq_pkg::QUEUE_DEPTH) begin
      send_sleep(dlsq_pkg::ID_W'($urandom()), dlsq_pkg::MS_W'($urandom_range(0, 39)));
    end
    send_sleep(8'hFF, 32'd0);
    send_sleep(8'h00, 32'hFFFF_FFFF);
    send_sleep(dlsq_pkg::ID_W'($urandom()), pick_duration());
    repeat (4) send_tick();
    wait_for_results();
  endtask

  task automatic test_output_stall();
    int i;
    -> hold_req;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_tick();
      else send_sleep(dlsq_pkg::ID_W'($urandom()), dlsq_pkg::MS_W'($urandom_range(0, 60)));
    end
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 6; i++) begin
      send_sleep(dlsq_pkg::ID_W'($urandom()), dlsq_pkg::MS_W'($urandom_range(0, 50)));
    end
    wait_for_results();
    for (i = 0; i < 6; i++) send_tick();
  endtask

  task automatic test_random_mix();
    int i;
    for (i = 0; i < 130; i++) begin
      tx_idle_on = (i >= 40);
      rx_idle_on = (i >= 40);
      if ($urandom_range(0, 99) < 45) send_tick();
      else send_sleep(dlsq_pkg::ID_W'($urandom()), pick_duration());
    end
  endtask

  // Long receiver hold-off, counted here once a test asks for it.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_req);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  // Receiver: draw a short wait per item, hold while asked, then take one item.
  always begin : receiver
    int wait_n;
    wait_n = rx_idle_on ? int'($urandom_range(0, 4)) : 0;
    @(negedge clk);
    while (wait_n > 0 || rx_hold) begin
      out_ready <= 1'b0;
      if (wait_n > 0) wait_n--;
      @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(rst_n && out_valid && out_ready));
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with none pending, target_id", -1, out_target_id);
      end else begin
        want = owed_results.pop_front();
        if (out_kind != want.kind) report_mismatch("kind", want.kind, out_kind);
        if (out_target_id != want.target_id)
          report_mismatch("target_id", want.target_id, out_target_id);
        if (out_status != want.status) report_mismatch("status", want.status, out_status);
        if (out_last != want.last) report_mismatch("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = dlsq_pkg::ACT_SLEEP;
    in_process_id  = '0;
    in_duration_ms = '0;
    shadow_count   = 0;
    rx_idle_on     = 1'b1;
    tx_idle_on     = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_queue();
    test_output_stall();
    test_drain_pause();
    test_random_mix();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) report_mismatch("results never delivered", 0,
                                                  owed_results.size());
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== delta_list_sleep_queue_unit.f =====
design/dlsq_pkg.sv
design/dlsq_div.sv
design/dlsq_engine.sv
design/delta_list_sleep_queue_unit.sv
dv/delta_list_sleep_queue_unit_tb.sv
